// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl, included by pair_invariant_mass
// expects clk and arst_n in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define PIM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pim assertion failed");

// antecedent implies consequent in the same cycle
`define PIM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pim assertion failed");

`endif

// File: hw/rtl/pim_pkg.sv
// types and widths for the pair invariant mass pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pim_pkg;

	localparam int E_IN_W   = 64;
	localparam int E_ROOT_W = 32;
	localparam int P2_W     = 68;
	localparam int P2_HI_W  = 34;
	localparam int P2_LO_W  = P2_W - P2_HI_W;
	localparam int ESUM_W   = 34;
	localparam int E2_W     = 2 * ESUM_W;
	localparam int M_IN_W   = 67;
	localparam int M_ROOT_W = 34;
	localparam int OUT_W    = 32;

	typedef struct packed {
		logic signed [31:0] px_a;
		logic signed [31:0] py_a;
		logic signed [31:0] pz_a;
		logic [30:0]        mass_a;
		logic signed [31:0] px_b;
		logic signed [31:0] py_b;
		logic signed [31:0] pz_b;
		logic [30:0]        mass_b;
	} pair_t;

	typedef struct packed {
		logic [OUT_W-1:0] inv_mass;
		logic             clamped_negative;
		logic             saturated;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/pim_stream_if.sv
// valid/ready stream interface carrying one payload type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface pim_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pim_sqrt_cell.sv
// one bit of a restoring square root, registered, with sideband
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module pim_sqrt_cell #(
	parameter int IN_W   = 64,
	parameter int ROOT_W = 32,
	parameter int SIDE_W = 1,
	parameter int BIT    = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IN_W-1:0]   in_rem,
	input  wire logic [ROOT_W-1:0] in_root,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [IN_W-1:0]        out_rem,
	output logic [ROOT_W-1:0]      out_root,
	output logic [SIDE_W-1:0]      out_side
);
	localparam int TW = 2 * ROOT_W + 2;

	logic              valid_q;
	logic [IN_W-1:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SIDE_W-1:0] side_q;
	logic [TW-1:0]     d_ext;
	logic [TW-1:0]     trial;
	logic              take;

	assign d_ext = TW'(in_rem);
	assign trial = (TW'(in_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
	assign take = d_ext >= trial;
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= take ? IN_W'(d_ext - trial) : in_rem;
			root_q <= take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_side  = side_q;
endmodule
`default_nettype wire

// File: hw/rtl/pim_sqrt.sv
// rounded square root as a chain of one-bit cells plus a rounding stage
// depends on pim_sqrt_cell
`timescale 1ns / 1ps
`default_nettype none
module pim_sqrt #(
	parameter int IN_W   = 64,
	parameter int ROOT_W = 32,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IN_W-1:0]   in_x,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ROOT_W:0]        out_root,
	output logic [SIDE_W-1:0]      out_side
);
	logic              vld_c  [0:ROOT_W];
	logic              rdy_c  [0:ROOT_W];
	logic [IN_W-1:0]   rem_c  [0:ROOT_W];
	logic [ROOT_W-1:0] root_c [0:ROOT_W];
	logic [SIDE_W-1:0] side_c [0:ROOT_W];

	logic              valid_q;
	logic [ROOT_W:0]   root_q;
	logic [SIDE_W-1:0] side_q;
	logic              gt;

	assign vld_c[0]  = in_valid;
	assign in_ready  = rdy_c[0];
	assign rem_c[0]  = in_x;
	assign root_c[0] = '0;
	assign side_c[0] = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
		pim_sqrt_cell #(
			.IN_W(IN_W), .ROOT_W(ROOT_W), .SIDE_W(SIDE_W), .BIT(ROOT_W - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[k]),
			.in_ready  (rdy_c[k]),
			.in_rem    (rem_c[k]),
			.in_root   (root_c[k]),
			.in_side   (side_c[k]),
			.out_valid (vld_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.out_rem   (rem_c[k+1]),
			.out_root  (root_c[k+1]),
			.out_side  (side_c[k+1])
		);
	end

	// round half up: remainder above root bumps it
	assign gt = rem_c[ROOT_W] > IN_W'(root_c[ROOT_W]);
	assign rdy_c[ROOT_W] = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy_c[ROOT_W]) begin
			valid_q <= vld_c[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[ROOT_W] && vld_c[ROOT_W]) begin
			root_q <= (ROOT_W+1)'(root_c[ROOT_W]) + (ROOT_W+1)'(gt);
			side_q <= side_c[ROOT_W];
		end
	end

	assign out_valid = valid_q;
	assign out_root  = root_q;
	assign out_side  = side_q;
endmodule
`default_nettype wire

// File: hw/rtl/pair_invariant_mass.sv
// top level: two-body invariant mass pipeline
// depends on pim_pkg, pim_stream_if, pim_sqrt, assert_macros.svh
//
// channel  dir  payload                                         handshake
// pair     in   pair_t: px/py/pz/mass of particles a and b      valid/ready
// mass     out  result_t: inv_mass, clamped_negative, saturated valid/ready
//
// one request per cycle sustained while the mass output is ready
// pipeline: 2 square/sum stages, 32 energy root cells + round, 3 stages for
// energy sum, its square and the difference, 34 mass root cells + round, output
// every stage holds its request until the next one frees, bubbles collapse
// reset clears all stage valids, payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pair_invariant_mass (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pim_stream_if.sink   pair,
	pim_stream_if.source mass
);
	import pim_pkg::*;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [32:0] mag_sum(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32] ? 33'(-s) : 33'(s);
	endfunction

	pair_t p;
	logic [31:0] ma [0:3];
	logic [31:0] mb [0:3];
	logic [32:0] ms [0:2];

	logic        v_s1, ld_s1;
	logic [63:0] sq_a_s1 [0:3];
	logic [63:0] sq_b_s1 [0:3];
	logic [65:0] sq_p_s1 [0:2];

	logic            v_s2, ld_s2;
	logic [E_IN_W-1:0] ex_a_s2, ex_b_s2;
	logic [P2_W-1:0] p2_s2;

	logic                rdy_a, rdy_b, e_in_rdy;
	logic                va, vb;
	logic [E_ROOT_W:0]   ea, eb;
	logic [P2_HI_W-1:0]  p2_hi;
	logic [P2_LO_W-1:0]  p2_lo;

	logic              v_s3, ld_s3, v_s4, ld_s4, v_s5, ld_s5;
	logic [ESUM_W-1:0] esum_s3;
	logic [P2_W-1:0]   p2_s3, p2_s4;
	logic [E2_W-1:0]   e2_s4;
	logic [M_IN_W-1:0] x_s5;
	logic              neg_s5;

	logic              m_in_rdy, m_vld, m_neg;
	logic [M_ROOT_W:0] m_root;

	logic    out_v_q, ld_o;
	result_t res_q;

	assign p = pair.data;
	assign ma[0] = mag32(p.px_a);
	assign ma[1] = mag32(p.py_a);
	assign ma[2] = mag32(p.pz_a);
	assign ma[3] = 32'(p.mass_a);
	assign mb[0] = mag32(p.px_b);
	assign mb[1] = mag32(p.py_b);
	assign mb[2] = mag32(p.pz_b);
	assign mb[3] = 32'(p.mass_b);
	assign ms[0] = mag_sum(p.px_a, p.px_b);
	assign ms[1] = mag_sum(p.py_a, p.py_b);
	assign ms[2] = mag_sum(p.pz_a, p.pz_b);

	// stage valids, each advances when empty or when the next one takes
	assign ld_o       = !out_v_q || mass.ready;
	assign ld_s5      = !v_s5 || m_in_rdy;
	assign ld_s4      = !v_s4 || ld_s5;
	assign ld_s3      = !v_s3 || ld_s4;
	assign e_in_rdy   = rdy_a && rdy_b;
	assign ld_s2      = !v_s2 || e_in_rdy;
	assign ld_s1      = !v_s1 || ld_s2;
	assign pair.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= pair.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= va && vb;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_o) out_v_q <= m_vld;
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (ld_s1 && pair.valid) begin
			for (int i = 0; i < 4; i++) begin
				sq_a_s1[i] <= ma[i] * ma[i];
				sq_b_s1[i] <= mb[i] * mb[i];
			end
			for (int i = 0; i < 3; i++) begin
				sq_p_s1[i] <= ms[i] * ms[i];
			end
		end
	end

	// radicand sums
	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			ex_a_s2 <= sq_a_s1[0] + sq_a_s1[1] + sq_a_s1[2] + sq_a_s1[3];
			ex_b_s2 <= sq_b_s1[0] + sq_b_s1[1] + sq_b_s1[2] + sq_b_s1[3];
			p2_s2   <= P2_W'(sq_p_s1[0]) + P2_W'(sq_p_s1[1]) + P2_W'(sq_p_s1[2]);
		end
	end

	// energy roots, momentum square rides along split over both chains
	pim_sqrt #(.IN_W(E_IN_W), .ROOT_W(E_ROOT_W), .SIDE_W(P2_HI_W)) u_sqrt_ea (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2 && rdy_b),
		.in_ready  (rdy_a),
		.in_x      (ex_a_s2),
		.in_side   (p2_s2[P2_W-1:P2_LO_W]),
		.out_valid (va),
		.out_ready (ld_s3 && vb),
		.out_root  (ea),
		.out_side  (p2_hi)
	);

	pim_sqrt #(.IN_W(E_IN_W), .ROOT_W(E_ROOT_W), .SIDE_W(P2_LO_W)) u_sqrt_eb (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2 && rdy_a),
		.in_ready  (rdy_b),
		.in_x      (ex_b_s2),
		.in_side   (p2_s2[P2_LO_W-1:0]),
		.out_valid (vb),
		.out_ready (ld_s3 && va),
		.out_root  (eb),
		.out_side  (p2_lo)
	);

	always_ff @(posedge clk) begin
		if (ld_s3 && va && vb) begin
			esum_s3 <= ESUM_W'(ea) + ESUM_W'(eb);
			p2_s3   <= {p2_hi, p2_lo};
		end
		if (ld_s4 && v_s3) begin
			e2_s4 <= esum_s3 * esum_s3;
			p2_s4 <= p2_s3;
		end
		if (ld_s5 && v_s4) begin
			neg_s5 <= P2_W'(e2_s4) < p2_s4;
			x_s5   <= (P2_W'(e2_s4) < p2_s4) ? '0 : M_IN_W'(P2_W'(e2_s4) - p2_s4);
		end
	end

	pim_sqrt #(.IN_W(M_IN_W), .ROOT_W(M_ROOT_W), .SIDE_W(1)) u_sqrt_m (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (m_in_rdy),
		.in_x      (x_s5),
		.in_side   (neg_s5),
		.out_valid (m_vld),
		.out_ready (ld_o),
		.out_root  (m_root),
		.out_side  (m_neg)
	);

	always_ff @(posedge clk) begin
		if (ld_o && m_vld) begin
			if (m_neg) begin
				res_q.inv_mass         <= '0;
				res_q.clamped_negative <= 1'b1;
				res_q.saturated        <= 1'b0;
			end else if (m_root[M_ROOT_W:OUT_W] != '0) begin
				res_q.inv_mass         <= '1;
				res_q.clamped_negative <= 1'b0;
				res_q.saturated        <= 1'b1;
			end else begin
				res_q.inv_mass         <= m_root[OUT_W-1:0];
				res_q.clamped_negative <= 1'b0;
				res_q.saturated        <= 1'b0;
			end
		end
	end

	assign mass.valid = out_v_q;
	assign mass.data  = res_q;

	`PIM_ASSERT_ALWAYS(a_energy_lockstep, va == vb)
	`PIM_ASSERT_IMPLY(a_flags_exclusive, out_v_q, !(res_q.clamped_negative && res_q.saturated))
	`PIM_ASSERT_IMPLY(a_clamp_zero, out_v_q && res_q.clamped_negative, res_q.inv_mass == '0)
	`PIM_ASSERT_IMPLY(a_sat_ones, out_v_q && res_q.saturated, res_q.inv_mass == '1)
endmodule
`default_nettype wire

// File: verif/tb_pair_invariant_mass.sv
// testbench for pair_invariant_mass: directed and random particle pairs,
// results checked against an in-bench integer model of the invariant mass
// depends on pim_pkg, pim_stream_if and the pair_invariant_mass rtl
`timescale 1ns / 1ps
module tb_pair_invariant_mass;
	import pim_pkg::*;

	logic clk;
	logic arst_n;

	pim_stream_if #(.payload_t(pair_t))   pair_ch ();
	pim_stream_if #(.payload_t(result_t)) mass_ch ();

	pair_invariant_mass dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair_ch.sink),
		.mass(mass_ch.source)
	);

	result_t expected_masses[$];
	int      error_count;
	bit      sink_idle_on;
	bit      source_idle_on;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// rounded square root, halves up
	function automatic logic [67:0] round_sqrt(logic [135:0] x);
		logic [67:0]  r;
		logic [67:0]  t;
		logic [135:0] rem;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			t = r | (68'd1 << b);
			if (136'(t) * 136'(t) <= x)
				r = t;
		end
		rem = x - 136'(r) * 136'(r);
		if (rem > 136'(r))
			r = r + 68'd1;
		return r;
	endfunction

	function automatic logic [67:0] particle_energy(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz, logic [30:0] m);
		logic [135:0] acc;
		logic [31:0]  ax;
		logic [31:0]  ay;
		logic [31:0]  az;
		ax = px[31] ? 32'(-px) : px;
		ay = py[31] ? 32'(-py) : py;
		az = pz[31] ? 32'(-pz) : pz;
		acc = 136'(m) * 136'(m) + 136'(ax) * 136'(ax) + 136'(ay) * 136'(ay)
			+ 136'(az) * 136'(az);
		return round_sqrt(acc);
	endfunction

	function automatic result_t pair_mass(pair_t p);
		result_t      r;
		logic [67:0]  esum;
		logic [135:0] e2;
		logic [135:0] p2;
		logic [67:0]  root;
		logic signed [32:0] s [3];
		logic [32:0]  a;
		esum = particle_energy(p.px_a, p.py_a, p.pz_a, p.mass_a)
			+ particle_energy(p.px_b, p.py_b, p.pz_b, p.mass_b);
		e2 = 136'(esum) * 136'(esum);
		s[0] = 33'(p.px_a) + 33'(p.px_b);
		s[1] = 33'(p.py_a) + 33'(p.py_b);
		s[2] = 33'(p.pz_a) + 33'(p.pz_b);
		p2 = '0;
		for (int i = 0; i < 3; i++) begin
			a = s[i][32] ? 33'(-s[i]) : s[i];
			p2 = p2 + 136'(a) * 136'(a);
		end
		r = '0;
		if (e2 < p2) begin
			r.clamped_negative = 1'b1;
		end else begin
			root = round_sqrt(e2 - p2);
			if (root > 68'hFFFFFFFF) begin
				r.inv_mass = '1;
				r.saturated = 1'b1;
			end else begin
				r.inv_mass = root[31:0];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic send_pair(pair_t p);
		pair_ch.valid <= 1'b1;
		pair_ch.data  <= p;
		expected_masses.push_back(pair_mass(p));
		@(posedge clk);
		while (!pair_ch.ready)
			@(posedge clk);
		if (source_idle_on) begin
			while ($urandom_range(99) < 27) begin
				pair_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n)
			mass_ch.ready <= sink_idle_on ? ($urandom_range(99) >= 27) : 1'b1;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && mass_ch.valid && mass_ch.ready) begin
			if (expected_masses.size() == 0) begin
				report_mismatch("unexpected result", mass_ch.data.inv_mass, '0);
			end else begin
				want = expected_masses.pop_front();
				if (mass_ch.data.inv_mass !== want.inv_mass)
					report_mismatch("inv_mass", mass_ch.data.inv_mass, want.inv_mass);
				if (mass_ch.data.clamped_negative !== want.clamped_negative)
					report_mismatch("clamped_negative",
						32'(mass_ch.data.clamped_negative), 32'(want.clamped_negative));
				if (mass_ch.data.saturated !== want.saturated)
					report_mismatch("saturated", 32'(mass_ch.data.saturated),
						32'(want.saturated));
			end
		end
	end

	function automatic logic [31:0] rand_comp(int scale);
		case (scale)
			0: return $urandom();
			1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
			2: return 32'($signed($urandom_range(2 * 65536)) - 65536);
			default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int    sc;
		sc = $urandom_range(3);
		p.px_a = rand_comp(sc);
		p.py_a = rand_comp($urandom_range(3) == 0 ? 0 : sc);
		p.pz_a = rand_comp(sc);
		p.mass_a = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(65536 * 200));
		p.px_b = $urandom_range(4) == 0 ? 32'(-p.px_a) : rand_comp(sc);
		p.py_b = rand_comp(sc);
		p.pz_b = rand_comp($urandom_range(3));
		p.mass_b = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(65536 * 200));
		return p;
	endfunction

	task automatic test_extremes();
		pair_t p;
		p = '0;
		send_pair(p);
		p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF};
		send_pair(p);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF};
		send_pair(p);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0};
		send_pair(p);
		p = '{32'hFFFF_FFFF, 32'd1, 32'd0, 31'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 31'd1};
		send_pair(p);
		// parallel, equal momenta, rest masses only
		p = '{32'd65536, 32'd0, 32'd0, 31'd65536, 32'd65536, 32'd0, 32'd0, 31'd65536};
		send_pair(p);
		p = '{32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF};
		send_pair(p);
		p = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 31'h2AAA_AAAA,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A988, 31'h5555_5555};
		send_pair(p);
	endtask

	task automatic test_massless_collinear();
		pair_t p;
		// collinear massless pairs, rounding can push the radicand below zero
		for (int i = 0; i < 16; i++) begin
			p = '0;
			p.px_a = $urandom_range(65536 * 1000);
			p.py_a = $urandom_range(7);
			p.px_b = $urandom_range(65536 * 1000);
			p.py_b = $urandom_range(7);
			p.pz_b = $urandom_range(3);
			send_pair(p);
		end
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_pair(rand_pair());
	endtask

	initial begin
		int wait_cycles;
		error_count = 0;
		sink_idle_on = 1'b0;
		source_idle_on = 1'b0;
		pair_ch.valid = 1'b0;
		pair_ch.data = '0;
		mass_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_massless_collinear();
		test_random(300);
		sink_idle_on = 1'b1;
		source_idle_on = 1'b1;
		test_random(800);
		pair_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (expected_masses.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (error_count == 0 && expected_masses.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule
